// ===== hdl/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants for the streaming pattern matcher
// Field widths, request kinds and the control bundles passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  localparam int NPS_PATTERN_MAX   = 64;
  localparam int NPS_POSITION_BITS = 16;

  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 6;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int OUT_W    = 16;
  localparam int GROUP_W  = 8;

  localparam logic [OUT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PATTERN = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_RESTART = 2'd2
  } nps_kind_t;

  // per-cycle commands broadcast along the cell row
  typedef struct packed {
    logic shift;
    logic clear;
    logic rotate;
    logic wr;
  } nps_cell_ctl_t;

  // what a request in flight carries down the pipe
  typedef struct packed {
    logic text;
    logic restart;
    logic fill_ok;
  } nps_tag_t;

endpackage

`default_nettype wire

// ===== hdl/nps_in_if.sv =====
// ----------------------------------------------------------------------------
// nps_in_if: request channel of the pattern matcher
// Valid/ready handshake with kind, pattern slot and data byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface nps_in_if;
  logic                         valid;
  logic                         ready;
  logic [nps_pkg::KIND_W-1:0]   kind;
  logic [nps_pkg::INDEX_W-1:0]  pattern_index;
  logic [nps_pkg::BYTE_W-1:0]   data_byte;

  modport source(output valid, kind, pattern_index, data_byte, input ready);
  modport sink(input valid, kind, pattern_index, data_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/nps_out_if.sv =====
// ----------------------------------------------------------------------------
// nps_out_if: match result channel of the pattern matcher
// Valid/ready handshake with start position, running count and first flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface nps_out_if;
  logic                        valid;
  logic                        ready;
  logic [nps_pkg::OUT_W-1:0]   match_position;
  logic [nps_pkg::OUT_W-1:0]   match_count;
  logic                        is_first;

  modport source(output valid, match_position, match_count, is_first, input ready);
  modport sink(input valid, match_position, match_count, is_first, output ready);
endinterface

`default_nettype wire

// ===== hdl/nps_cell.sv =====
// ----------------------------------------------------------------------------
// nps_cell: one cell of the matcher row
// Holds one text byte of the window and one byte of the rotating pattern ring,
// passes both to its neighbor and flags equality.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_cell #(
  parameter int PATTERN_MAX = nps_pkg::NPS_PATTERN_MAX,
  parameter int IDX         = 0
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  nps_pkg::nps_cell_ctl_t               ctl,
  input  wire  [nps_pkg::BYTE_W-1:0]           text_in,
  input  wire  [nps_pkg::BYTE_W-1:0]           ring_in,
  input  wire  [$clog2(PATTERN_MAX)-1:0]       wr_idx,
  input  wire  [nps_pkg::BYTE_W-1:0]           wr_byte,
  input  wire  [$clog2(PATTERN_MAX+1)-1:0]     len,
  output logic [nps_pkg::BYTE_W-1:0]           text_out,
  output logic [nps_pkg::BYTE_W-1:0]           ring_out,
  output logic                                 eq
);

  localparam int IW   = $clog2(PATTERN_MAX);
  localparam int LENW = $clog2(PATTERN_MAX+1);

  logic [nps_pkg::BYTE_W-1:0] win;
  logic [nps_pkg::BYTE_W-1:0] ring;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (ctl.clear) begin
      win <= '0;
    end else if (ctl.shift) begin
      win <= text_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      ring <= ring_in;
    end else if (ctl.wr && (wr_idx == IW'(IDX))) begin
      ring <= wr_byte;
    end
  end

  // cells past the active length never block a match
  assign eq       = (LENW'(IDX) >= len) || (win == ring);
  assign text_out = win;
  assign ring_out = ring;

endmodule

`default_nettype wire

// ===== hdl/nps_row.sv =====
// ----------------------------------------------------------------------------
// nps_row: chain of matcher cells
// Text shifts from cell 0 upward; the pattern ring rotates with wraparound.
// Equality flags are reduced in groups into registers.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_row #(
  parameter int PATTERN_MAX = nps_pkg::NPS_PATTERN_MAX,
  parameter int NUM_GRP     = (PATTERN_MAX + nps_pkg::GROUP_W - 1) / nps_pkg::GROUP_W
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  nps_pkg::nps_cell_ctl_t               ctl,
  input  wire  [nps_pkg::BYTE_W-1:0]           text_byte,
  input  wire  [$clog2(PATTERN_MAX)-1:0]       wr_idx,
  input  wire  [nps_pkg::BYTE_W-1:0]           wr_byte,
  input  wire  [$clog2(PATTERN_MAX+1)-1:0]     len,
  input  wire                                  adv,
  output logic [NUM_GRP-1:0]                   grp
);

  localparam int GW = nps_pkg::GROUP_W;

  logic [nps_pkg::BYTE_W-1:0] text_chain [PATTERN_MAX];
  logic [nps_pkg::BYTE_W-1:0] ring_chain [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]     eq;
  logic [NUM_GRP*GW-1:0]      eq_pad;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [nps_pkg::BYTE_W-1:0] t_in;
    logic [nps_pkg::BYTE_W-1:0] r_in;
    if (i == 0) begin : g_head
      assign t_in = text_byte;
      assign r_in = ring_chain[PATTERN_MAX-1];
    end else begin : g_body
      assign t_in = text_chain[i-1];
      assign r_in = ring_chain[i-1];
    end

    nps_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .IDX         (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .text_in  (t_in),
      .ring_in  (r_in),
      .wr_idx   (wr_idx),
      .wr_byte  (wr_byte),
      .len      (len),
      .text_out (text_chain[i]),
      .ring_out (ring_chain[i]),
      .eq       (eq[i])
    );
  end

  always_comb begin
    eq_pad                = '1;
    eq_pad[PATTERN_MAX-1:0] = eq;
  end

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    always_ff @(posedge clk) begin
      if (adv) begin
        grp[g] <= &eq_pad[g*GW +: GW];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nps_tally.sv =====
// ----------------------------------------------------------------------------
// nps_tally: final match decision, running count and result register
// Finishes the equality reduction, keeps the saturating match count and
// drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_tally #(
  parameter int POSITION_BITS = nps_pkg::NPS_POSITION_BITS,
  parameter int NUM_GRP       = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          adv,
  input  nps_pkg::nps_tag_t            tag,
  input  wire  [POSITION_BITS-1:0]     start,
  input  wire  [NUM_GRP-1:0]           grp,
  nps_out_if.source                    out_ch
);

  logic [nps_pkg::OUT_W-1:0] count;
  logic [nps_pkg::OUT_W-1:0] count_next;
  logic [31:0]               start_wide;
  logic                      hit;

  assign hit        = tag.text && tag.fill_ok && (&grp);
  assign start_wide = 32'(start);
  assign count_next = (count == nps_pkg::COUNT_MAX) ? count : count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= hit;
      if (tag.restart) begin
        count <= '0;
      end else if (hit) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit) begin
      out_ch.match_position <= start_wide[nps_pkg::OUT_W-1:0];
      out_ch.match_count    <= count_next;
      out_ch.is_first       <= (count == '0);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/naive_pattern_match_stream.sv =====
// ----------------------------------------------------------------------------
// naive_pattern_match_stream: streaming exact pattern matcher
// Pattern bytes are written by slot; text bytes stream in and every occurrence
// of the pattern yields its start position, a saturating count and a first flag.
// ----------------------------------------------------------------------------
// One request is taken per cycle and each text byte passes the cell, group and
// result registers before its match result appears. The row of PATTERN_MAX cells
// holds the text window and a ring of pattern bytes aligned to the active length.
// A length write starts a realignment of that ring, one cell step per cycle while
// no text byte is in the first stage; no request is taken during it. A stalled
// result holds the whole pipe, so input ready follows output ready combinationally.
`default_nettype none

module naive_pattern_match_stream #(
  parameter int PATTERN_MAX   = nps_pkg::NPS_PATTERN_MAX,
  parameter int POSITION_BITS = nps_pkg::NPS_POSITION_BITS
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_wr_en,
  input  wire  [nps_pkg::LEN_W-1:0]    cfg_wr_data,
  nps_in_if.sink                       in_ch,
  nps_out_if.source                    out_ch
);

  localparam int IW      = $clog2(PATTERN_MAX);
  localparam int LENW    = $clog2(PATTERN_MAX+1);
  localparam int DW      = ((IW > nps_pkg::INDEX_W) ? IW : nps_pkg::INDEX_W) + 2;
  localparam int NUM_GRP = (PATTERN_MAX + nps_pkg::GROUP_W - 1) / nps_pkg::GROUP_W;

  logic [nps_pkg::LEN_W-1:0] len_cfg;
  logic [LENW-1:0]           len_eff;
  logic [IW-1:0]             rot;
  logic [IW-1:0]             rot_next;
  logic [IW-1:0]             tgt;
  logic                      rot_step;
  logic [POSITION_BITS-1:0]  pos;
  logic [POSITION_BITS-1:0]  start;
  logic [LENW-1:0]           fill;
  logic [LENW-1:0]           fill_next;
  logic                      adv;
  logic                      acc;
  logic                      is_text;
  logic                      is_restart;
  logic                      is_wr;
  logic                      slot_ok;
  logic [DW-1:0]             wr_diff;
  logic [IW-1:0]             wr_idx;
  nps_pkg::nps_cell_ctl_t    ctl;
  nps_pkg::nps_tag_t         tag_now;
  nps_pkg::nps_tag_t         tag_s1;
  nps_pkg::nps_tag_t         tag_s2;
  logic [LENW-1:0]           len_s1;
  logic [POSITION_BITS-1:0]  start_s1;
  logic [POSITION_BITS-1:0]  start_s2;
  logic [NUM_GRP-1:0]        grp;

  // clamp the length register into 1..PATTERN_MAX
  always_comb begin
    if (len_cfg == '0) begin
      len_eff = LENW'(1);
    end else if (32'(len_cfg) > PATTERN_MAX) begin
      len_eff = LENW'(PATTERN_MAX);
    end else begin
      len_eff = LENW'(len_cfg);
    end
  end

  // ring cell i holds pattern slot (rot - i) mod PATTERN_MAX
  assign tgt      = IW'(len_eff - 1'b1);
  assign rot_next = (rot == IW'(PATTERN_MAX-1)) ? '0 : rot + 1'b1;
  assign rot_step = (rot != tgt) && !tag_s1.text;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv && (rot == tgt);
  assign acc         = in_ch.valid && in_ch.ready;

  assign slot_ok = DW'(in_ch.pattern_index) < DW'(PATTERN_MAX);
  assign wr_diff = DW'(rot) + DW'(PATTERN_MAX) - DW'(in_ch.pattern_index);
  assign wr_idx  = (wr_diff >= DW'(PATTERN_MAX)) ? IW'(wr_diff - DW'(PATTERN_MAX))
                                                 : IW'(wr_diff);

  always_comb begin
    is_text    = 1'b0;
    is_restart = 1'b0;
    is_wr      = 1'b0;
    if (acc) begin
      unique case (nps_pkg::nps_kind_t'(in_ch.kind))
        nps_pkg::KIND_PATTERN: is_wr      = slot_ok;
        nps_pkg::KIND_TEXT:    is_text    = 1'b1;
        nps_pkg::KIND_RESTART: is_restart = 1'b1;
        default: ;
      endcase
    end
  end

  assign fill_next = (fill == LENW'(PATTERN_MAX)) ? fill : fill + 1'b1;
  assign start     = pos - POSITION_BITS'(len_eff - 1'b1);

  always_comb begin
    ctl.shift  = is_text;
    ctl.clear  = is_restart;
    ctl.rotate = rot_step;
    ctl.wr     = is_wr;
    tag_now.text    = is_text;
    tag_now.restart = is_restart;
    tag_now.fill_ok = fill_next >= len_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg <= nps_pkg::LEN_W'(1);
      rot     <= '0;
      pos     <= '0;
      fill    <= '0;
      tag_s1  <= '0;
      tag_s2  <= '0;
    end else begin
      if (cfg_wr_en) begin
        len_cfg <= cfg_wr_data;
      end
      if (rot_step) begin
        rot <= rot_next;
      end
      if (is_restart) begin
        pos  <= '0;
        fill <= '0;
      end else if (is_text) begin
        pos  <= pos + 1'b1;
        fill <= fill_next;
      end
      if (adv) begin
        tag_s1 <= tag_now;
        tag_s2 <= tag_s1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len_s1   <= len_eff;
      start_s1 <= start;
      start_s2 <= start_s1;
    end
  end

  nps_row #(
    .PATTERN_MAX (PATTERN_MAX),
    .NUM_GRP     (NUM_GRP)
  ) u_row (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .text_byte (in_ch.data_byte),
    .wr_idx    (wr_idx),
    .wr_byte   (in_ch.data_byte),
    .len       (len_s1),
    .adv       (adv),
    .grp       (grp)
  );

  nps_tally #(
    .POSITION_BITS (POSITION_BITS),
    .NUM_GRP       (NUM_GRP)
  ) u_tally (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .tag    (tag_s2),
    .start  (start_s2),
    .grp    (grp),
    .out_ch (out_ch)
  );

  a_no_req_while_realign: assert property (@(posedge clk) disable iff (rst)
    acc |-> (rot == tgt))
    else $error("request taken while pattern ring is realigning");

  a_rot_single_step: assert property (@(posedge clk) disable iff (rst)
    (rot != $past(rot)) |-> $past(rot_step))
    else $error("pattern ring alignment moved without a rotate step");

  a_first_is_one: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.is_first) |-> (out_ch.match_count == nps_pkg::OUT_W'(1)))
    else $error("first match reported with count other than one");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.match_count != '0))
    else $error("match reported with zero count");

endmodule

`default_nettype wire
